// ----- hw/rtl/nearest_cluster_head_assign_top_assert.svh -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: assertion macros
// Property templates shared by the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CLUSTER_HEAD_ASSIGN_TOP_ASSERT_SVH
`define NEAREST_CLUSTER_HEAD_ASSIGN_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NCHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NCHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ncha_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: package
// Widths, codes and the head table entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package ncha_pkg;

  localparam int MAX_HEADS_DEF = 16;
  localparam int COORD_BITS    = 16;
  localparam int NODE_W        = 10;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 3;
  localparam int SLOT_OUT_W    = 4;
  localparam int SQ_W          = 2 * COORD_BITS;
  localparam int SUM_W         = SQ_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_ASSIGN = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_ASSIGNED = 3'd1,
    ST_IS_HEAD  = 3'd2,
    ST_NO_HEADS = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } head_entry_t;

  typedef struct packed {
    logic              vld;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [NODE_W-1:0] node;
  } dist_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ncha_head_mem.sv -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: head table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncha_head_mem #(
  parameter int MAX_HEADS = ncha_pkg::MAX_HEADS_DEF,
  parameter int SLOT_W    = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [SLOT_W-1:0]         wr_addr,
  input  wire ncha_pkg::head_entry_t wr_data,
  input  wire                      rd_en,
  input  wire [SLOT_W-1:0]         rd_addr,
  output ncha_pkg::head_entry_t    rd_data
);

  ncha_pkg::head_entry_t mem [MAX_HEADS];
  ncha_pkg::head_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ncha_dist.sv -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: distance stage
// Squares the x and y differences between the query and one head.
// ----------------------------------------------------------------------------
`default_nettype none

module ncha_dist #(
  parameter int SLOT_W = 4
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_vld,
  input  wire [SLOT_W-1:0]                     in_slot,
  input  wire ncha_pkg::head_entry_t           entry,
  input  wire [ncha_pkg::COORD_BITS-1:0]       qx,
  input  wire [ncha_pkg::COORD_BITS-1:0]       qy,
  output ncha_pkg::dist_res_t                  res,
  output logic [SLOT_W-1:0]                    res_slot
);

  logic [ncha_pkg::COORD_BITS-1:0] dx;
  logic [ncha_pkg::COORD_BITS-1:0] dy;
  logic                            vld_r;
  logic [ncha_pkg::SQ_W-1:0]       sq_x_r;
  logic [ncha_pkg::SQ_W-1:0]       sq_y_r;
  logic [ncha_pkg::NODE_W-1:0]     node_r;
  logic [SLOT_W-1:0]               slot_r;

  always_comb begin
    dx = (qx >= entry.x) ? (qx - entry.x) : (entry.x - qx);
    dy = (qy >= entry.y) ? (qy - entry.y) : (entry.y - qy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    sq_x_r <= ncha_pkg::SQ_W'(dx) * ncha_pkg::SQ_W'(dx);
    sq_y_r <= ncha_pkg::SQ_W'(dy) * ncha_pkg::SQ_W'(dy);
    node_r <= entry.node;
    slot_r <= in_slot;
  end

  always_comb begin
    res.vld  = vld_r;
    res.sq_x = sq_x_r;
    res.sq_y = sq_y_r;
    res.node = node_r;
    res_slot = slot_r;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_cluster_head_assign_top.sv -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: top level
// Head table with clear, append and nearest-head query.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. Clear, append, a query for
// a node that is itself a head, and a query with an empty table finish on
// acceptance: the result register loads at the edge that accepts the word. A query
// that must search walks the loaded heads through the single read port of
// the head table, one entry per cycle, followed by the squaring stage and
// the compare; its result is loaded in S_RESULT once the output is free,
// and the next word is taken once that result has left. Ties go to the lowest
// slot. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_cluster_head_assign_top #(
  parameter int MAX_HEADS = ncha_pkg::MAX_HEADS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [ncha_pkg::OP_W-1:0]           in_opcode,
  input  wire [ncha_pkg::NODE_W-1:0]         in_node_number,
  input  wire [15:0]                         in_pos_x,
  input  wire [15:0]                         in_pos_y,
  input  wire                                in_is_head,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ncha_pkg::STATUS_W-1:0]      out_status,
  output logic [ncha_pkg::NODE_W-1:0]        out_head_number,
  output logic [ncha_pkg::SLOT_OUT_W-1:0]    out_head_slot
);

  localparam int SLOT_W  = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int COUNT_W = $clog2(MAX_HEADS + 1);
  localparam int CB      = ncha_pkg::COORD_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                             state_r, state_nxt;
  logic [COUNT_W-1:0]                 count_r, count_nxt;
  logic [COUNT_W-1:0]                 iss_r, iss_nxt;
  logic [CB-1:0]                      qx_r, qx_nxt;
  logic [CB-1:0]                      qy_r, qy_nxt;
  logic                               rd_vld_r, rd_vld_nxt;
  logic [ncha_pkg::SUM_W-1:0]         best_d_r, best_d_nxt;
  logic [SLOT_W-1:0]                  best_slot_r, best_slot_nxt;
  logic [ncha_pkg::NODE_W-1:0]        best_node_r, best_node_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [ncha_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [ncha_pkg::NODE_W-1:0]        out_number_r, out_number_nxt;
  logic [ncha_pkg::SLOT_OUT_W-1:0]    out_slot_r, out_slot_nxt;

  logic                               out_free;
  logic                               in_acc;
  logic                               issue;
  logic                               wr_en;
  ncha_pkg::head_entry_t              wr_data;
  ncha_pkg::head_entry_t              rd_data;
  ncha_pkg::dist_res_t                dres;
  logic [SLOT_W-1:0]                  dslot;
  logic [ncha_pkg::SUM_W-1:0]         dsum;
  logic                               take;
  logic                               last;
  logic [COUNT_W+ncha_pkg::SLOT_OUT_W-1:0] count_ext;
  logic [SLOT_W+ncha_pkg::SLOT_OUT_W-1:0]  best_ext;

  // The read issued last cycle was for slot iss_r - 1.
  function automatic logic [SLOT_W-1:0] best_slot_addr(input logic [COUNT_W-1:0] iss);
    logic [COUNT_W-1:0] prev;
    prev = iss - COUNT_W'(1);
    return prev[SLOT_W-1:0];
  endfunction

  ncha_head_mem #(
    .MAX_HEADS (MAX_HEADS),
    .SLOT_W    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[SLOT_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (iss_r[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  ncha_dist #(
    .SLOT_W (SLOT_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .in_slot  (best_slot_addr(iss_r)),
    .entry    (rd_data),
    .qx       (qx_r),
    .qy       (qy_r),
    .res      (dres),
    .res_slot (dslot)
  );

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = (state_r != S_IDLE) || !out_free;
    in_acc    = in_valid && !in_stall;
    issue     = (state_r == S_SCAN) && (iss_r != count_r);
    dsum      = ncha_pkg::SUM_W'(dres.sq_x) + ncha_pkg::SUM_W'(dres.sq_y);
    take      = (dslot == '0) || (dsum < best_d_r);
    last      = (COUNT_W'(dslot) == (count_r - COUNT_W'(1)));
    count_ext = {{ncha_pkg::SLOT_OUT_W{1'b0}}, count_r};
    best_ext  = {{ncha_pkg::SLOT_OUT_W{1'b0}}, best_slot_r};

    wr_en        = 1'b0;
    wr_data.node = in_node_number;
    wr_data.x    = in_pos_x[CB-1:0];
    wr_data.y    = in_pos_y[CB-1:0];

    state_nxt      = state_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    rd_vld_nxt     = issue;
    best_d_nxt     = best_d_r;
    best_slot_nxt  = best_slot_r;
    best_node_nxt  = best_node_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_number_nxt = out_number_r;
    out_slot_nxt   = out_slot_r;

    if (issue) begin
      iss_nxt = iss_r + COUNT_W'(1);
    end

    if (dres.vld && take) begin
      best_d_nxt    = dsum;
      best_slot_nxt = dslot;
      best_node_nxt = dres.node;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ncha_pkg::ST_DONE;
          out_number_nxt = '0;
          out_slot_nxt   = '0;
          case (in_opcode)
            ncha_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            ncha_pkg::OP_APPEND: begin
              if (count_r >= COUNT_W'(MAX_HEADS)) begin
                out_status_nxt = ncha_pkg::ST_FULL;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + COUNT_W'(1);
                out_number_nxt = in_node_number;
                out_slot_nxt   = count_ext[ncha_pkg::SLOT_OUT_W-1:0];
              end
            end
            ncha_pkg::OP_ASSIGN: begin
              if (in_is_head) begin
                out_status_nxt = ncha_pkg::ST_IS_HEAD;
                out_number_nxt = in_node_number;
              end else if (count_r == '0) begin
                out_status_nxt = ncha_pkg::ST_NO_HEADS;
              end else begin
                out_valid_nxt = 1'b0;
                qx_nxt        = in_pos_x[CB-1:0];
                qy_nxt        = in_pos_y[CB-1:0];
                iss_nxt       = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              out_status_nxt = ncha_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (dres.vld && last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ncha_pkg::ST_ASSIGNED;
          out_number_nxt = best_node_r;
          out_slot_nxt   = best_ext[ncha_pkg::SLOT_OUT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    best_d_r     <= best_d_nxt;
    best_slot_r  <= best_slot_nxt;
    best_node_r  <= best_node_nxt;
    out_status_r <= out_status_nxt;
    out_number_r <= out_number_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_head_number = out_number_r;
  assign out_head_slot   = out_slot_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ncha_chk.sv -----
// ----------------------------------------------------------------------------
// Nearest cluster head assignment: port checker
// Watches the ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_cluster_head_assign_top_assert.svh"

module ncha_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire [ncha_pkg::OP_W-1:0]         in_opcode,
  input wire [ncha_pkg::NODE_W-1:0]       in_node_number,
  input wire                              in_is_head,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [ncha_pkg::STATUS_W-1:0]     out_status,
  input wire [ncha_pkg::NODE_W-1:0]       out_head_number,
  input wire [ncha_pkg::SLOT_OUT_W-1:0]   out_head_slot
);

  `NCHA_ASSERT_NEXT(a_clear_done, in_valid && !in_stall && in_opcode == ncha_pkg::OP_CLEAR, out_valid && out_status == ncha_pkg::ST_DONE && out_head_slot == '0, "clear did not complete in one cycle")

  `NCHA_ASSERT_NEXT(a_head_self, in_valid && !in_stall && in_opcode == ncha_pkg::OP_ASSIGN && in_is_head, out_valid && out_status == ncha_pkg::ST_IS_HEAD && out_head_number == $past(in_node_number), "head node not reported as its own head")

  `NCHA_ASSERT_NOW(a_flag_zero, out_valid && (out_status == ncha_pkg::ST_NO_HEADS || out_status == ncha_pkg::ST_FULL), out_head_number == '0 && out_head_slot == '0, "flagged word carries a head")

  `NCHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_head_number) && $stable(out_head_slot), "stalled result word changed")

endmodule

bind nearest_cluster_head_assign_top ncha_chk u_ncha_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .in_node_number  (in_node_number),
  .in_is_head      (in_is_head),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_head_number (out_head_number),
  .out_head_slot   (out_head_slot)
);

`default_nettype wire
